/* rtl/uled_pkg.sv */
// shared types and constants for the serial console line buffer
// no dependencies; used by every rtl file of the block except uled_ram

package uled_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    // default ring depth in bytes
    localparam int RING_DEPTH_DEF = 128;

    // register reset values
    localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'd13;
    localparam logic [BYTE_W-1:0] ERASE_RESET    = 8'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE    = 1'd1;

    // command codes carried on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE  = 2'd0,
        CMD_TX_DONE  = 2'd1,
        CMD_READ     = 2'd2,
        CMD_TX_QUEUE = 2'd3
    } cmd_t;

    // classified operation handed from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] data;
        logic              is_end;
        logic              is_erase;
    } op_t;

endpackage

/* rtl/uled_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies

module uled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/uled_front.sv */
// front end: config registers, command classification and a two-entry op queue
// depends on uled_pkg

module uled_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [uled_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [uled_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [uled_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [uled_pkg::CMD_W-1:0]          s_tuser,
    output logic                                op_valid,
    input  logic                                op_ready,
    output uled_pkg::op_t                       op
);

    logic [uled_pkg::BYTE_W-1:0] line_end_reg;
    logic [uled_pkg::BYTE_W-1:0] erase_reg;

    uled_pkg::op_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    uled_pkg::op_t in_op;
    logic          push;
    logic          pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_end_reg <= uled_pkg::LINE_END_RESET;
            erase_reg    <= uled_pkg::ERASE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                uled_pkg::CFG_LINE_END: line_end_reg <= cfg_wdata;
                uled_pkg::CFG_ERASE:    erase_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify the incoming item
    always_comb begin
        in_op.cmd      = uled_pkg::cmd_t'(s_tuser);
        in_op.data     = s_tdata;
        in_op.is_end   = (s_tdata == line_end_reg);
        in_op.is_erase = (s_tdata == erase_reg);
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign op_valid = (count_reg != 2'd0);
    assign pop      = op_valid && op_ready;
    assign op       = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // queue pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

/* rtl/uled_back.sv */
// back end: receive and transmit rings, echo, erase, line flag and result register
// depends on uled_pkg and uled_ram

module uled_back #(
    parameter int RING_DEPTH = uled_pkg::RING_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               op_valid,
    output logic                               op_ready,
    input  uled_pkg::op_t                      op,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [uled_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    typedef struct packed {
        logic                        tx_start;
        logic [uled_pkg::BYTE_W-1:0] tx_byte;
        logic                        tx_from_ram;
        logic                        read_valid;
        logic                        read_last;
        logic                        line_ready;
        logic                        rx_ovf;
        logic                        tx_ovf;
    } res_t;

    // pointers are {phase, address}; phase flips on each wrap
    logic [AW:0] tx_w_reg, tx_w_next;
    logic [AW:0] tx_r_reg, tx_r_next;
    logic [AW:0] rx_w_reg, rx_w_next;
    logic [AW:0] rx_r_reg, rx_r_next;
    logic        busy_reg, busy_next;
    logic        line_reg, line_next;
    logic        res_valid_reg;
    res_t        res_reg, res_next;

    logic        fire;
    logic        tx_full, rx_full, rx_empty;
    logic        tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0] tx_raddr;
    logic [uled_pkg::BYTE_W-1:0] tx_rdata, rx_rdata;
    logic [uled_pkg::BYTE_W-1:0] out_tx_byte, out_read_byte;

    function automatic logic [AW:0] ptr_inc(input logic [AW:0] p);
        logic [AW:0] r;
        if (p[AW-1:0] == LAST_ADDR) begin
            r = {~p[AW], {AW{1'b0}}};
        end else begin
            r = {p[AW], p[AW-1:0] + AW'(1)};
        end
        return r;
    endfunction

    function automatic logic [AW:0] ptr_dec(input logic [AW:0] p);
        logic [AW:0] r;
        if (p[AW-1:0] == {AW{1'b0}}) begin
            r = {~p[AW], LAST_ADDR};
        end else begin
            r = {p[AW], p[AW-1:0] - AW'(1)};
        end
        return r;
    endfunction

    assign op_ready = !res_valid_reg || m_tready;
    assign fire     = op_valid && op_ready;

    assign tx_full  = (tx_w_reg[AW-1:0] == tx_r_reg[AW-1:0]) && (tx_w_reg[AW] != tx_r_reg[AW]);
    assign rx_full  = (rx_w_reg[AW-1:0] == rx_r_reg[AW-1:0]) && (rx_w_reg[AW] != rx_r_reg[AW]);
    assign rx_empty = (rx_w_reg == rx_r_reg);

    // execute one operation
    always_comb begin
        tx_w_next = tx_w_reg;
        tx_r_next = tx_r_reg;
        rx_w_next = rx_w_reg;
        rx_r_next = rx_r_reg;
        busy_next = busy_reg;
        line_next = line_reg;
        tx_we     = 1'b0;
        tx_re     = 1'b0;
        rx_we     = 1'b0;
        rx_re     = 1'b0;
        tx_raddr  = tx_r_reg[AW-1:0];
        res_next  = '0;

        unique case (op.cmd) inside
            uled_pkg::CMD_RX_BYTE, uled_pkg::CMD_TX_QUEUE: begin
                // queue for transmit; an idle transmitter always has an empty ring
                if (tx_full) begin
                    res_next.tx_ovf = 1'b1;
                end else begin
                    tx_we     = fire;
                    tx_w_next = ptr_inc(tx_w_reg);
                end
                if (!busy_reg) begin
                    busy_next        = 1'b1;
                    res_next.tx_start = 1'b1;
                    res_next.tx_byte  = op.data;
                end
                if (op.cmd == uled_pkg::CMD_RX_BYTE) begin
                    if (op.is_end) begin
                        line_next = 1'b1;
                    end else begin
                        line_next = 1'b0;
                        if (op.is_erase) begin
                            if (!rx_empty) begin
                                rx_w_next = ptr_dec(rx_w_reg);
                            end
                        end else if (rx_full) begin
                            res_next.rx_ovf = 1'b1;
                        end else begin
                            rx_we     = fire;
                            rx_w_next = ptr_inc(rx_w_reg);
                        end
                    end
                end
            end
            uled_pkg::CMD_TX_DONE: begin
                // retire the byte in flight, start the next one from the ring
                if (busy_reg) begin
                    tx_r_next = ptr_inc(tx_r_reg);
                    tx_raddr  = tx_r_next[AW-1:0];
                    if (tx_r_next != tx_w_reg) begin
                        tx_re                = fire;
                        res_next.tx_start    = 1'b1;
                        res_next.tx_from_ram = 1'b1;
                    end else begin
                        busy_next = 1'b0;
                    end
                end
            end
            uled_pkg::CMD_READ: begin
                if (!rx_empty) begin
                    rx_re               = fire;
                    res_next.read_valid = 1'b1;
                    rx_r_next           = ptr_inc(rx_r_reg);
                end
                res_next.read_last = (rx_r_next == rx_w_reg);
            end
            default: ;
        endcase
        res_next.line_ready = line_next;
    end

    // ring state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_w_reg      <= '0;
            tx_r_reg      <= '0;
            rx_w_reg      <= '0;
            rx_r_reg      <= '0;
            busy_reg      <= 1'b0;
            line_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            tx_w_reg      <= tx_w_next;
            tx_r_reg      <= tx_r_next;
            rx_w_reg      <= rx_w_next;
            rx_r_reg      <= rx_r_next;
            busy_reg      <= busy_next;
            line_reg      <= line_next;
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    // transmit ring
    uled_ram #(
        .WIDTH (uled_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .clk   (aclk),
        .we    (tx_we),
        .waddr (tx_w_reg[AW-1:0]),
        .wdata (op.data),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // receive ring
    uled_ram #(
        .WIDTH (uled_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .clk   (aclk),
        .we    (rx_we),
        .waddr (rx_w_reg[AW-1:0]),
        .wdata (op.data),
        .re    (rx_re),
        .raddr (rx_r_reg[AW-1:0]),
        .rdata (rx_rdata)
    );

    // merge registered ram data into the result
    assign out_tx_byte   = res_reg.tx_from_ram ? tx_rdata : res_reg.tx_byte;
    assign out_read_byte = res_reg.read_valid ? rx_rdata : '0;

    assign m_tvalid = res_valid_reg;
    assign m_tlast  = res_reg.read_last;
    assign m_tdata  = {3'b000, res_reg.tx_ovf, res_reg.rx_ovf, res_reg.line_ready,
                       out_read_byte, res_reg.read_valid, out_tx_byte, res_reg.tx_start};

endmodule

/* rtl/uart_line_editor_echo_fifo.sv */
// top level of the serial console line buffer with echo and erase
// depends on uled_pkg, uled_front, uled_back (and uled_ram below it)

// Takes one command per clock cycle with no gaps while m_tready stays high.
// Each accepted command waits in the front op queue, and its result is then
// held in the back result register, which is fed by the registered ring
// reads, until the result transfers on the result channel. A stalled
// result holds the back end; the two-entry op queue takes up to two more
// commands, then s_tready drops and returns the cycle after the stalled result
// transfers. Both rings are plain RAMs of RING_DEPTH bytes each with no
// clearing pass, so the block is ready right after reset. An idle transmitter
// starts on a queued or echoed byte at once; a transmit done command starts
// the next waiting byte. Config writes belong while idle.

module uart_line_editor_echo_fifo #(
    parameter int RING_DEPTH = uled_pkg::RING_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [uled_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uled_pkg::BYTE_W-1:0]        cfg_wdata,
    // command channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [uled_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic [uled_pkg::CMD_W-1:0]         s_tuser,   // [1:0] cmd
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] tx_start, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
    // [18] line_ready, [19] rx_overflow, [20] tx_overflow, [23:21] zero
    output logic [uled_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast    // read_last
);

    uled_pkg::op_t op;
    logic          op_valid;
    logic          op_ready;

    // accept and classify commands
    uled_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op)
    );

    // carry out commands on the rings
    uled_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/uled_checker.sv */
// port-level checks for the serial console line buffer, bound to the top level
// depends on uled_pkg and uart_line_editor_echo_fifo

module uled_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [uled_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a read result never starts transmit or reports an overflow
    a_read_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[0] && !m_tdata[19] && !m_tdata[20])
        else $error("read result carries transmit or overflow flags");

    // a valid result never both starts transmit and returns a received byte
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("tx start together with read valid");

    // a dropped transmit byte means the transmitter was busy
    a_txovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> !m_tdata[0])
        else $error("tx overflow together with tx start");

endmodule

bind uart_line_editor_echo_fifo uled_checker u_uled_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* bench/tb_uart_line_editor_echo_fifo.sv */
// self-checking bench for the serial console line buffer with echo and erase
// needs uled_pkg and the uart_line_editor_echo_fifo rtl; runs a directed table, then
// random command bursts under four flow-control phases against a cycle-free predictor

module tb_uart_line_editor_echo_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import uled_pkg::*;

    localparam int RING        = RING_DEPTH_DEF;
    localparam int PTR_W       = $clog2(RING) + 1;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 220;
    localparam int DIR_ROWS    = 24;

    // one result, laid out as {m_tlast, m_tdata[20:0]}
    typedef struct packed {
        logic              read_last;
        logic              tx_overflow;
        logic              rx_overflow;
        logic              line_ready;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_start;
    } echo_res_t;

    typedef struct {
        cmd_t              op;
        logic [BYTE_W-1:0] data;
        bit                known;
        echo_res_t         res;
    } dir_row_t;

    // results that can be read off at a glance
    localparam echo_res_t RES_QUIET      = '0;
    localparam echo_res_t RES_EMPTY_READ = '{read_last: 1'b1, default: '0};
    localparam echo_res_t RES_ECHO_ERASE = '{tx_start: 1'b1, tx_byte: 8'h08, default: '0};

    // directed commands: empty read, idle done, erase on empty line, extremes,
    // line end, erase after data, queue while busy, ring drains, queue while idle
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{CMD_READ,     8'h00, 1'b1, RES_EMPTY_READ},
        '{CMD_TX_DONE,  8'hff, 1'b1, RES_QUIET},
        '{CMD_RX_BYTE,  8'h08, 1'b1, RES_ECHO_ERASE},
        '{CMD_RX_BYTE,  8'h41, 1'b0, RES_QUIET},
        '{CMD_RX_BYTE,  8'hff, 1'b0, RES_QUIET},
        '{CMD_RX_BYTE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_RX_BYTE,  8'h0d, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_RX_BYTE,  8'h08, 1'b0, RES_QUIET},
        '{CMD_TX_QUEUE, 8'haa, 1'b0, RES_QUIET},
        '{CMD_READ,     8'h00, 1'b0, RES_QUIET},
        '{CMD_READ,     8'hff, 1'b0, RES_QUIET},
        '{CMD_READ,     8'h00, 1'b1, RES_EMPTY_READ},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_TX_QUEUE, 8'h55, 1'b0, RES_QUIET},
        '{CMD_TX_DONE,  8'h00, 1'b0, RES_QUIET},
        '{CMD_RX_BYTE,  8'h0d, 1'b0, RES_QUIET},
        '{CMD_RX_BYTE,  8'h0d, 1'b0, RES_QUIET},
        '{CMD_READ,     8'h00, 1'b0, RES_QUIET}
    };

    // per-phase register settings and flow-control rates
    logic [BYTE_W-1:0] end_tab   [PHASES] = '{8'hff, 8'h00, 8'h2a, 8'h0d};
    logic [BYTE_W-1:0] erase_tab [PHASES] = '{8'h00, 8'hff, 8'h2a, 8'h7f};
    int                gap_tab   [PHASES] = '{0, 73, 0, 27};
    int                stall_tab [PHASES] = '{0, 0, 73, 27};

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [BYTE_W-1:0]       cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic [CMD_W-1:0]        s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;

    // line buffer state as the predictor sees it
    logic [BYTE_W-1:0] line_end_q = LINE_END_RESET;
    logic [BYTE_W-1:0] erase_q    = ERASE_RESET;
    logic [BYTE_W-1:0] rx_line_buf [RING];
    logic [BYTE_W-1:0] tx_echo_buf [RING];
    logic [PTR_W-1:0]  rx_wr = '0;
    logic [PTR_W-1:0]  rx_rd = '0;
    logic [PTR_W-1:0]  tx_wr = '0;
    logic [PTR_W-1:0]  tx_rd = '0;
    logic              tx_busy_q   = 1'b0;
    logic              line_flag_q = 1'b0;

    echo_res_t console_results_q [$];
    int        err_cnt     = 0;
    int        sent_cnt    = 0;
    int        gap_pct     = 0;
    int        stall_pct   = 0;
    int        quiet_cycles = 0;

    uart_line_editor_echo_fifo #(
        .RING_DEPTH(RING)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tuser   (s_tuser),   // [1:0] cmd
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] tx_start, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
                                // [18] line_ready, [19] rx_overflow, [20] tx_overflow
        .m_tlast   (m_tlast)    // read_last
    );

    always #5 aclk = ~aclk;

    // occupancy of a ring, pointers count modulo twice the depth
    function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] wr,
                                                   input logic [PTR_W-1:0] rd);
        return wr - rd;
    endfunction

    function automatic bit tx_append(input logic [BYTE_W-1:0] b);
        if (ring_fill(tx_wr, tx_rd) >= RING) begin
            return 1'b0;
        end
        tx_echo_buf[tx_wr[PTR_W-2:0]] = b;
        tx_wr = tx_wr + PTR_W'(1);
        return 1'b1;
    endfunction

    // an idle transmitter picks up the oldest waiting byte
    function automatic void tx_launch(inout echo_res_t r);
        if (!tx_busy_q && tx_wr != tx_rd) begin
            tx_busy_q = 1'b1;
            r.tx_start = 1'b1;
            r.tx_byte  = tx_echo_buf[tx_rd[PTR_W-2:0]];
        end
    endfunction

    // next state of the line buffer and the result of one command
    function automatic echo_res_t line_buffer_step(input cmd_t op, input logic [BYTE_W-1:0] b);
        echo_res_t r;
        r = '0;
        case (op)
            CMD_RX_BYTE: begin
                if (!tx_append(b)) r.tx_overflow = 1'b1;
                tx_launch(r);
                if (b == line_end_q) begin
                    line_flag_q = 1'b1;
                end else begin
                    line_flag_q = 1'b0;
                    if (b == erase_q) begin
                        if (rx_wr != rx_rd) rx_wr = rx_wr - PTR_W'(1);
                    end else if (ring_fill(rx_wr, rx_rd) >= RING) begin
                        r.rx_overflow = 1'b1;
                    end else begin
                        rx_line_buf[rx_wr[PTR_W-2:0]] = b;
                        rx_wr = rx_wr + PTR_W'(1);
                    end
                end
            end
            CMD_TX_DONE: begin
                if (tx_busy_q) begin
                    tx_rd = tx_rd + PTR_W'(1);
                    tx_busy_q = 1'b0;
                    tx_launch(r);
                end
            end
            CMD_READ: begin
                if (rx_wr != rx_rd) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_line_buf[rx_rd[PTR_W-2:0]];
                    rx_rd = rx_rd + PTR_W'(1);
                end
                r.read_last = (rx_wr == rx_rd);
            end
            default: begin
                if (!tx_append(b)) r.tx_overflow = 1'b1;
                tx_launch(r);
            end
        endcase
        r.line_ready = line_flag_q;
        return r;
    endfunction

    // present one command, hold it until the transfer, then log its result
    task automatic send_item(input cmd_t op, input logic [BYTE_W-1:0] b,
                             input bit known = 1'b0, input echo_res_t fixed_res = '0);
        echo_res_t r;
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        r = line_buffer_step(op, b);
        console_results_q.push_back(known ? fixed_res : r);
        sent_cnt++;
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (console_results_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_LINE_END) line_end_q = val;
        else erase_q = val;
    endtask

    // empty both rings with reads and transmit dones in random order
    task automatic drain_rings();
        int reads;
        int dones;
        reads = int'(ring_fill(rx_wr, rx_rd)) + $urandom_range(0, 1);
        dones = int'(ring_fill(tx_wr, tx_rd)) + $urandom_range(0, 1);
        while (reads > 0 || dones > 0) begin
            if (dones == 0 || (reads > 0 && $urandom_range(0, 1) == 0)) begin
                send_item(CMD_READ, 8'($urandom_range(0, 255)));
                reads--;
            end else begin
                send_item(CMD_TX_DONE, 8'($urandom_range(0, 255)));
                dones--;
            end
        end
    endtask

    // random bursts: typed lines, drains, transmit traffic and noise
    task automatic run_bursts(input int budget, input bit flood);
        int                stop;
        int                kind;
        int                n;
        int                i;
        logic [BYTE_W-1:0] b;
        stop = sent_cnt + budget;
        // overfill both rings with ordinary bytes, then empty them
        if (flood) begin
            for (i = 0; i < RING + 8; i++) begin
                do b = 8'($urandom_range(0, 255)); while (b == line_end_q || b == erase_q);
                send_item(CMD_RX_BYTE, b);
            end
            drain_rings();
        end
        while (sent_cnt < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                n = $urandom_range(0, 10);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 99) < 15) b = erase_q;
                    else b = 8'($urandom_range(0, 255));
                    send_item(CMD_RX_BYTE, b);
                    if ($urandom_range(0, 99) < 40) send_item(CMD_TX_DONE, 8'h00);
                end
                send_item(CMD_RX_BYTE, line_end_q);
            end else if (kind < 65) begin
                drain_rings();
            end else if (kind < 80) begin
                n = int'(ring_fill(tx_wr, tx_rd)) + $urandom_range(0, 2);
                for (i = 0; i < n; i++) send_item(CMD_TX_DONE, 8'($urandom_range(0, 255)));
            end else if (kind < 90) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) send_item(CMD_TX_QUEUE, 8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) begin
                    send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        echo_res_t got;
        echo_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[20:0]};
            if (console_results_q.size() == 0) begin
                $error("result transfer with nothing outstanding: 0x%0h", got);
                err_cnt++;
            end else begin
                want = console_results_q.pop_front();
                check_field("tx_start", want.tx_start, got.tx_start);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("read_last", want.read_last, got.read_last);
                check_field("line_ready", want.line_ready, got.line_ready);
                check_field("rx_overflow", want.rx_overflow, got.rx_overflow);
                check_field("tx_overflow", want.tx_overflow, got.tx_overflow);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p;
        int i;
        // hold the synchronous reset, then release it at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table at the reset register values
        for (i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].known, dir_tab[i].res);
        end

        // random phases, registers rewritten while the block is idle
        for (p = 0; p < PHASES; p++) begin
            wait_quiet();
            write_reg(CFG_LINE_END, end_tab[p]);
            write_reg(CFG_ERASE, erase_tab[p]);
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            gap_pct   = gap_tab[p];
            stall_pct = stall_tab[p];
            run_bursts(PHASE_ITEMS, (p == 0 || p == PHASES - 1));
        end

        wait_quiet();
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
